[rtl/md5ps_pkg.sv]
// Package for the MD5 password search block: widths, MD5 constant tables,
// the alphabet ROM and the round schedule. No dependencies.
package md5ps_pkg;

  localparam int IDX_W     = 36;
  localparam int DIG_W     = 6;
  localparam int PW_CHARS  = 6;
  localparam int PW_W      = 8 * PW_CHARS;
  localparam int CHUNK_W   = 6;
  localparam int DIV_CELLS = (IDX_W / CHUNK_W) * PW_CHARS;
  localparam int ROUNDS    = 64;
  localparam int TARGETS   = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  localparam logic [DIG_W-1:0] CHARSET_SIZE = 6'd62;

  // Register index layout: bits [2:1] pick the target, bit 0 the half.
  localparam logic       REG_AB   = 1'b0;
  localparam logic       REG_CD   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd8;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] BIT_LEN  = 32'(PW_W);

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [4:0] rot_of(input logic [5:0] i);
    return ROT_AMT[{i[5:4], i[1:0]}];
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] word_of(input logic [5:0] i);
    logic [7:0] g;
    unique case (i[5:4])
      2'd0:    g = {4'd0, i[3:0]};
      2'd1:    g = 8'(5 * i + 1);
      2'd2:    g = 8'(3 * i + 5);
      default: g = 8'(7 * i);
    endcase
    return g[3:0];
  endfunction

  // Alphabet: a..z, A..Z, 0..9; codes past the end wrap.
  function automatic logic [7:0] alpha_of(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] w;
    w = (d >= CHARSET_SIZE) ? d - CHARSET_SIZE : d;
    if (w < 6'd26)      return 8'h61 + 8'(w);
    else if (w < 6'd52) return 8'h41 + 8'(w - 6'd26);
    else                return 8'h30 + 8'(w - 6'd52);
  endfunction

endpackage

[rtl/md5ps_div_cell.sv]
// One cell of the base-62 digit chain: folds six index bits into the running
// remainder. Depends on md5ps_pkg.
module md5ps_div_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         last,
  input  logic                         in_valid,
  input  logic [md5ps_pkg::IDX_W-1:0]  in_num,
  input  logic [md5ps_pkg::IDX_W-1:0]  in_quo,
  input  logic [md5ps_pkg::DIG_W-1:0]  in_rem,
  input  logic [md5ps_pkg::IDX_W-1:0]  in_dig,
  output logic                         out_valid,
  output logic [md5ps_pkg::IDX_W-1:0]  out_num,
  output logic [md5ps_pkg::IDX_W-1:0]  out_quo,
  output logic [md5ps_pkg::DIG_W-1:0]  out_rem,
  output logic [md5ps_pkg::IDX_W-1:0]  out_dig
);
  import md5ps_pkg::*;

  logic [DIG_W:0]     r;
  logic [CHUNK_W-1:0] qbits;
  logic [IDX_W-1:0]   quo_new;

  always_comb begin
    r = {1'b0, in_rem};
    qbits = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      r = {r[DIG_W-1:0], in_num[IDX_W-1-j]};
      if (r >= {1'b0, CHARSET_SIZE}) begin
        r = r - {1'b0, CHARSET_SIZE};
        qbits[CHUNK_W-1-j] = 1'b1;
      end
    end
    quo_new = {in_quo[IDX_W-CHUNK_W-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // On the closing cell of a division the remainder is a digit; restart on
  // the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      if (last) begin
        out_num <= quo_new;
        out_quo <= '0;
        out_rem <= '0;
        out_dig <= {in_dig[IDX_W-DIG_W-1:0], r[DIG_W-1:0]};
      end else begin
        out_num <= {in_num[IDX_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
        out_quo <= quo_new;
        out_rem <= r[DIG_W-1:0];
        out_dig <= in_dig;
      end
    end
  end

endmodule

[rtl/md5ps_round_cell.sv]
// One MD5 round as a registered cell of the round chain. Depends on
// md5ps_pkg for the round constants and schedule.
module md5ps_round_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [5:0]                  round,
  input  logic                        in_valid,
  input  logic [31:0]                 in_a,
  input  logic [31:0]                 in_b,
  input  logic [31:0]                 in_c,
  input  logic [31:0]                 in_d,
  input  logic [md5ps_pkg::PW_W-1:0]  in_pw,
  output logic                        out_valid,
  output logic [31:0]                 out_a,
  output logic [31:0]                 out_b,
  output logic [31:0]                 out_c,
  output logic [31:0]                 out_d,
  output logic [md5ps_pkg::PW_W-1:0]  out_pw
);
  import md5ps_pkg::*;

  logic [31:0] f;
  logic [31:0] m;
  logic [31:0] sum;
  logic [63:0] rot;
  logic [3:0]  g;

  always_comb begin
    unique case (round[5:4])
      2'd0:    f = (in_b & in_c) | (~in_b & in_d);
      2'd1:    f = (in_d & in_b) | (~in_d & in_c);
      2'd2:    f = in_b ^ in_c ^ in_d;
      default: f = in_c ^ (in_b | ~in_d);
    endcase
    g = word_of(round);
    // Only three message words are non-zero for a six-character block.
    case (g)
      4'd0:    m = in_pw[31:0];
      4'd1:    m = {8'h00, PAD_BYTE, in_pw[PW_W-1:32]};
      4'd14:   m = BIT_LEN;
      default: m = '0;
    endcase
    sum = in_a + f + ROUND_K[round] + m;
    rot = {sum, sum} << rot_of(round);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a  <= in_d;
      out_b  <= in_b + rot[63:32];
      out_c  <= in_b;
      out_d  <= in_c;
      out_pw <= in_pw;
    end
  end

endmodule

[rtl/md5_password_search.sv]
// Top level of the MD5 password search: digit chain, alphabet lookup, round
// chain, target compare. Depends on md5ps_pkg, md5ps_div_cell, md5ps_round_cell.
//
// Use:
//   Present a 36-bit candidate index on candidate_index with cand_valid; the
//   word is taken when cand_valid and cand_ready are both high. Exactly one
//   result word leaves on res_valid/res_ready for every candidate, in order.
//   The index is split into six base-62 digits (most significant first, the
//   top digit wrapping), mapped to a-z, A-Z, 0-9, padded into one MD5 block
//   and hashed. The digest is compared against four targets written on the
//   cfg_we/cfg_index/cfg_data port (index 2t holds words a|b, 2t+1 holds c|d);
//   new_hits flags targets matched for the first time since reset.
// Pipeline: 36 digit cells, 1 lookup stage, 64 round cells and 1 output
//   register lie between acceptance and res_valid.
// Throughput: one candidate per cycle unless the output stalls; every cell
//   hands its word on each enabled cycle, so the chain length sets latency.
// Reset: clears all stage valid bits, the found flags and the targets.
// Stall: when res_valid is high and res_ready low the whole chain holds and
//   cand_ready drops; a taken output frees the chain in the same cycle.
module md5_password_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cand_valid,
  output logic                              cand_ready,
  input  logic [md5ps_pkg::IDX_W-1:0]       candidate_index,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [md5ps_pkg::TARGETS-1:0]     new_hits,
  output logic [md5ps_pkg::PW_W-1:0]        password,
  output logic [31:0]                       digest_a,
  output logic [31:0]                       digest_b,
  output logic [31:0]                       digest_c,
  output logic [31:0]                       digest_d,
  input  logic                              cfg_we,
  input  logic [md5ps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [md5ps_pkg::CFG_W-1:0]       cfg_data
);
  import md5ps_pkg::*;

  logic en;

  // Target registers and first-match flags.
  logic [CFG_W-1:0]   tgt_ab [TARGETS];
  logic [CFG_W-1:0]   tgt_cd [TARGETS];
  logic [TARGETS-1:0] found;

  // Digit chain links.
  logic             dv   [DIV_CELLS+1];
  logic [IDX_W-1:0] dnum [DIV_CELLS+1];
  logic [IDX_W-1:0] dquo [DIV_CELLS+1];
  logic [DIG_W-1:0] drem [DIV_CELLS+1];
  logic [IDX_W-1:0] ddig [DIV_CELLS+1];

  // Round chain links.
  logic            rv  [ROUNDS+1];
  logic [31:0]     ra  [ROUNDS+1];
  logic [31:0]     rb  [ROUNDS+1];
  logic [31:0]     rc  [ROUNDS+1];
  logic [31:0]     rd  [ROUNDS+1];
  logic [PW_W-1:0] rpw [ROUNDS+1];

  logic [31:0]        fa, fb, fc, fd;
  logic [TARGETS-1:0] eq;
  logic [TARGETS-1:0] hits;

  // Advance everything unless a finished word is stuck at the output.
  assign en         = !res_valid || res_ready;
  assign cand_ready = en;

  assign dv[0]   = cand_valid;
  assign dnum[0] = candidate_index;
  assign dquo[0] = '0;
  assign drem[0] = '0;
  assign ddig[0] = '0;

  for (genvar s = 0; s < DIV_CELLS; s++) begin : g_div
    md5ps_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .last      ((s % CHUNK_W) == CHUNK_W - 1),
      .in_valid  (dv[s]),
      .in_num    (dnum[s]),
      .in_quo    (dquo[s]),
      .in_rem    (drem[s]),
      .in_dig    (ddig[s]),
      .out_valid (dv[s+1]),
      .out_num   (dnum[s+1]),
      .out_quo   (dquo[s+1]),
      .out_rem   (drem[s+1]),
      .out_dig   (ddig[s+1])
    );
  end

  // Alphabet lookup: digit field k holds character k, first character low.
  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < PW_CHARS; k++) begin
        rpw[0][8*k +: 8] <= alpha_of(ddig[DIV_CELLS][DIG_W*k +: DIG_W]);
      end
    end
  end

  assign ra[0] = IV_A;
  assign rb[0] = IV_B;
  assign rc[0] = IV_C;
  assign rd[0] = IV_D;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    md5ps_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .round     (6'(i)),
      .in_valid  (rv[i]),
      .in_a      (ra[i]),
      .in_b      (rb[i]),
      .in_c      (rc[i]),
      .in_d      (rd[i]),
      .in_pw     (rpw[i]),
      .out_valid (rv[i+1]),
      .out_a     (ra[i+1]),
      .out_b     (rb[i+1]),
      .out_c     (rc[i+1]),
      .out_d     (rd[i+1]),
      .out_pw    (rpw[i+1])
    );
  end

  // Final add and compare against every target.
  always_comb begin
    fa = IV_A + ra[ROUNDS];
    fb = IV_B + rb[ROUNDS];
    fc = IV_C + rc[ROUNDS];
    fd = IV_D + rd[ROUNDS];
    for (int t = 0; t < TARGETS; t++) begin
      eq[t] = ({fb, fa} == tgt_ab[t]) && ({fd, fc} == tgt_cd[t]);
    end
    hits = eq & ~found;
  end

  // Configuration writes; indexes past the last register drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TARGETS; t++) begin
        tgt_ab[t] <= '0;
        tgt_cd[t] <= '0;
      end
    end else if (cfg_we && cfg_index < REG_COUNT) begin
      if (cfg_index[0] == REG_AB) begin
        tgt_ab[cfg_index[2:1]] <= cfg_data;
      end else if (cfg_index[0] == REG_CD) begin
        tgt_cd[cfg_index[2:1]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= rv[ROUNDS];
      if (rv[ROUNDS]) begin
        found <= found | hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_hits <= hits;
      password <= rpw[ROUNDS];
      digest_a <= fa;
      digest_b <= fb;
      digest_c <= fc;
      digest_d <= fd;
    end
  end

endmodule

[rtl/md5ps_checker.sv]
// Port-level checks for md5_password_search, bound to the top level.
// Depends on md5ps_pkg.
module md5ps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cand_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [md5ps_pkg::PW_W-1:0]    password,
  input logic [31:0]                   digest_a
);
  import md5ps_pkg::*;

  // Output word holds while stalled.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(password) && $stable(digest_a))
    else $error("result word changed while stalled");

  // An empty output never blocks the input side.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cand_ready)
    else $error("input blocked with empty output");

  // A stalled output must block the input side.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !cand_ready)
    else $error("input taken while output stalled");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

endmodule

bind md5_password_search md5ps_checker u_md5ps_checker (
  .clk        (clk),
  .rst        (rst),
  .cand_ready (cand_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .password   (password),
  .digest_a   (digest_a)
);

[tb/sv/md5_password_search_tb.sv]
// Self-checking testbench for md5_password_search: a local MD5 predictor
// fed with every accepted candidate word; results checked in order.
// Depends on md5ps_pkg (port widths) and the md5_password_search RTL.
`timescale 1ns / 100ps

module md5_password_search_tb;
  import md5ps_pkg::*;

  localparam longint unsigned SPACE       = 64'd56800235584; // 62^6
  localparam int              CYCLE_LIMIT = 600000;
  localparam int              DRAIN       = 120;  // longer than the pipeline latency

  typedef struct packed {
    logic [TARGETS-1:0] hits;
    logic [PW_W-1:0]    pw;
    logic [31:0]        a, b, c, d;
  } md5_hit_t;

  logic                 clk, rst;
  logic                 cand_valid, cand_ready;
  logic [IDX_W-1:0]     candidate_index;
  logic                 res_valid, res_ready;
  logic [TARGETS-1:0]   new_hits;
  logic [PW_W-1:0]      password;
  logic [31:0]          digest_a, digest_b, digest_c, digest_d;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  md5_password_search dut (.*);

  // Predictor state: target mirror and the sticky per-target found flags.
  logic [63:0]        target_mirror [8];
  logic [TARGETS-1:0] found_mirror;
  md5_hit_t           pending_digests [$];

  int send_idle_pct, recv_stall_pct;
  int words_sent, words_checked, hits_seen, mismatches;
  int cycle_count = 0;

  logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Base-62 digits, most significant first; the top digit wraps by plain
  // remainder. First character lands in the lowest byte.
  function automatic logic [PW_W-1:0] password_of(logic [IDX_W-1:0] idx);
    longint unsigned rest;
    int              dgt;
    logic [PW_W-1:0] pw;
    rest = idx;
    pw   = '0;
    for (int i = PW_CHARS - 1; i >= 0; i--) begin
      dgt  = int'(rest % 62);
      rest = rest / 62;
      if (dgt < 26)      pw[8*i +: 8] = 8'(8'h61 + dgt);
      else if (dgt < 52) pw[8*i +: 8] = 8'(8'h41 + dgt - 26);
      else               pw[8*i +: 8] = 8'(8'h30 + dgt - 52);
    end
    return pw;
  endfunction

  // Single padded block: six characters, 0x80, bit length 48 in word 14.
  function automatic logic [127:0] md5_of(logic [PW_W-1:0] pw);
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, s;
    int          g, sh;
    foreach (m[i]) m[i] = '0;
    m[0]  = pw[31:0];
    m[1]  = {8'h00, 8'h80, pw[47:32]};
    m[14] = 32'd48;
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d;          g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d);       g = (7 * i) % 16;
      end
      sh = SHIFT_TAB[(i / 16) * 4 + (i % 4)];
      s  = a + f + K_TAB[i] + m[g];
      t  = d;
      d  = c;
      c  = b;
      b  = b + ((s << sh) | (s >> (32 - sh)));
      a  = t;
    end
    return {32'h10325476 + d, 32'h98badcfe + c, 32'hefcdab89 + b, 32'h67452301 + a};
  endfunction

  // Work out one result and advance the found flags, in acceptance order.
  function automatic md5_hit_t predict_search(logic [IDX_W-1:0] idx);
    md5_hit_t    r;
    logic [127:0] dg;
    r.pw = password_of(idx);
    dg   = md5_of(r.pw);
    {r.d, r.c, r.b, r.a} = dg;
    r.hits = '0;
    for (int t = 0; t < TARGETS; t++) begin
      if ({r.b, r.a} == target_mirror[2*t] && {r.d, r.c} == target_mirror[2*t+1]
          && !found_mirror[t]) begin
        r.hits[t]       = 1'b1;
        found_mirror[t] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index(bit in_range);
    logic [IDX_W-1:0] v;
    v = {4'($urandom_range(15)), 32'($urandom())};
    if (in_range) v = IDX_W'(64'(v) % SPACE);
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_digests.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: decide back-pressure at each falling edge.
  always @(negedge clk) begin
    if (rst) res_ready = 1'b0;
    else     res_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each taken result word against the oldest expectation.
  always @(posedge clk) begin
    md5_hit_t exp_r;
    if (!rst && res_valid && res_ready) begin
      if (pending_digests.size() == 0) begin
        $error("result word with nothing expected: password %h", password);
        mismatches++;
      end else begin
        exp_r = pending_digests.pop_front();
        words_checked++;
        if (new_hits != 0) hits_seen++;
        if (new_hits !== exp_r.hits) begin
          $error("new_hits: expected %h actual %h", exp_r.hits, new_hits);
          mismatches++;
        end
        if (password !== exp_r.pw) begin
          $error("password: expected %h actual %h", exp_r.pw, password);
          mismatches++;
        end
        if (digest_a !== exp_r.a) begin
          $error("digest_a: expected %h actual %h", exp_r.a, digest_a);
          mismatches++;
        end
        if (digest_b !== exp_r.b) begin
          $error("digest_b: expected %h actual %h", exp_r.b, digest_b);
          mismatches++;
        end
        if (digest_c !== exp_r.c) begin
          $error("digest_c: expected %h actual %h", exp_r.c, digest_c);
          mismatches++;
        end
        if (digest_d !== exp_r.d) begin
          $error("digest_d: expected %h actual %h", exp_r.d, digest_d);
          mismatches++;
        end
      end
    end
  end

  // Offer one candidate word; idle cycles are drawn per cycle. Valid stays
  // high from one word to the next when no idle cycle falls between them.
  task automatic send_candidate(logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      cand_valid = 1'b0;
      @(negedge clk);
    end
    cand_valid      = 1'b1;
    candidate_index = idx;
    @(posedge clk);
    while (!cand_ready) @(posedge clk);
    pending_digests.push_back(predict_search(idx));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain_results();
    cand_valid = 1'b0;
    while (pending_digests.size() != 0) @(negedge clk);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic write_target(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < REG_COUNT) target_mirror[idx] = value;
  endtask

  // Aim target t at the digest of a given candidate.
  task automatic aim_target(int t, logic [IDX_W-1:0] idx);
    logic [127:0] dg;
    dg = md5_of(password_of(idx));
    write_target(CFG_IDX_W'(2*t),     dg[63:0]);
    write_target(CFG_IDX_W'(2*t + 1), dg[127:64]);
  endtask

  // Field extremes and each alphabet boundary, with all targets at reset.
  task automatic test_directed_edges();
    send_candidate('0);
    send_candidate(IDX_W'(SPACE - 1));
    send_candidate(IDX_W'(SPACE));              // top digit wraps to 'a'
    send_candidate('1);                         // all bits set, wrapping
    send_candidate(36'd25);                     // last lowercase
    send_candidate(36'd26);                     // first uppercase
    send_candidate(36'd51);                     // last uppercase
    send_candidate(36'd52);                     // first digit
    send_candidate(36'd61);                     // last digit
    send_candidate(36'd62);
    send_candidate(IDX_W'(SPACE * 2 + 12345));  // cut to 36 bits; lands inside the space
    drain_results();
  endtask

  // First match reports once, several targets in one word, writes keep flags,
  // out-of-range register indexes are ignored.
  task automatic test_target_hits();
    aim_target(0, 36'd1000);
    aim_target(1, 36'd0);
    aim_target(2, 36'd777777);
    aim_target(3, 36'd777777);
    write_target(4'd8,  64'hffff_ffff_ffff_ffff);
    write_target(4'd15, 64'h0);
    send_candidate(36'd1000);
    send_candidate(36'd1000);                   // already found: no hit
    send_candidate(36'd777777);                 // two targets at once
    send_candidate(36'd5);
    send_candidate(36'd0);
    drain_results();
    // Rewriting a found target must not re-arm it.
    aim_target(1, 36'd0);
    send_candidate(36'd0);
    drain_results();
    for (int i = 0; i < 8; i++) write_target(CFG_IDX_W'(i), 64'hffff_ffff_ffff_ffff);
    send_candidate(IDX_W'(SPACE - 1));
    drain_results();
  endtask

  // Random words under one idling mix; one in-range candidate aimed at a
  // target so that later phases can still see a first hit where a flag is free.
  task automatic test_random_phase(int idle_pct, int stall_pct, int words,
                                   bit pause_midway, logic [63:0] fill);
    logic [IDX_W-1:0] aimed;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < 8; i++) write_target(CFG_IDX_W'(i), fill);
    aimed = rand_index(1'b1);
    aim_target($urandom_range(TARGETS - 1), aimed);
    for (int n = 0; n < words; n++) begin
      if (n == words / 3) send_candidate(aimed);
      // Hold off until the pipeline has emptied, then carry on.
      if (pause_midway && n == words / 2) drain_results();
      send_candidate(rand_index($urandom_range(99) < 80));
    end
    drain_results();
  endtask

  initial begin
    rst             = 1'b1;
    cand_valid      = 1'b0;
    candidate_index = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    words_sent      = 0;
    words_checked   = 0;
    hits_seen       = 0;
    mismatches      = 0;
    found_mirror    = '0;
    foreach (target_mirror[i]) target_mirror[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_edges();
    test_target_hits();
    test_random_phase(0,  0,  420, 1'b0, 64'h0);
    test_random_phase(51, 0,  420, 1'b1, 64'hffff_ffff_ffff_ffff);
    test_random_phase(0,  51, 420, 1'b0, 64'h0123_4567_89ab_cdef);
    test_random_phase(27, 27, 420, 1'b1, 64'h0);

    drain_results();
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d candidate words, %0d results checked, %0d with first hits,",
             words_sent, words_checked, hits_seen);
    $display("under free flow, sender gaps, receiver stalls and both together");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/md5ps_pkg.sv
rtl/md5ps_div_cell.sv
rtl/md5ps_round_cell.sv
rtl/md5_password_search.sv
rtl/md5ps_checker.sv
tb/sv/md5_password_search_tb.sv
